@@ hdl/vcc_pkg.sv @@
`default_nettype none

package vcc_pkg;

  // descriptor table geometry
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned NEXT_W      = 16;

  // item kinds
  localparam logic KIND_WRITE    = 1'b0;
  localparam logic KIND_VALIDATE = 1'b1;

  // descriptor flag bit positions
  localparam int unsigned FLAG_NEXT     = 0;
  localparam int unsigned FLAG_INDIRECT = 2;

  // one stored descriptor, as much of it as the walk needs
  typedef struct packed {
    logic              len_nonzero;
    logic              has_next;
    logic              indirect;
    logic [NEXT_W-1:0] next;
  } entry_t;

  // read request from the walker to the table
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef enum logic {
    WalkIdle,
    WalkStep
  } walk_state_e;

endpackage

`default_nettype wire

@@ hdl/vcc_table.sv @@
`default_nettype none

module vcc_table (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  vcc_pkg::rd_req_t  rd_req_i,
  output vcc_pkg::entry_t   rd_entry_o,
  input  wire               wr_en_i,
  input  wire [3:0]         wr_addr_i,
  input  vcc_pkg::entry_t   wr_entry_i
);
  import vcc_pkg::*;

  entry_t                 mem_q [TABLE_DEPTH];
  entry_t                 rd_data_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic                   rd_valid_q;

  // descriptor storage, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (rd_req_i.en) begin
      rd_data_q <= mem_q[rd_req_i.addr];
    end
  end

  // valid bits stand in for clearing the table at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_req_i.en) begin
        rd_valid_q <= valid_q[rd_req_i.addr];
      end
    end
  end

  // an entry never written reads as all zero
  assign rd_entry_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

@@ hdl/vcc_walker.sv @@
`default_nettype none

module vcc_walker #(
  parameter int unsigned RING_ENTRIES = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  wire               kind_i,
  input  wire [15:0]        head_index_i,
  input  vcc_pkg::entry_t   rd_entry_i,
  output vcc_pkg::rd_req_t  rd_req_o,
  output logic              busy_o,
  output logic              done_o,
  output logic              chain_ok_o
);
  import vcc_pkg::*;

  walk_state_e            state_q, state_d;
  logic [TABLE_DEPTH-1:0] visited_q, visited_d;
  logic                   done_q, done_d;
  logic                   ok_q, ok_d;

  logic                   validate;
  logic                   head_in_range;
  logic                   next_in_range;
  logic                   next_seen;
  logic                   step_fail;
  logic                   step_end;

  assign validate      = start_i && (state_q == WalkIdle) && (kind_i == KIND_VALIDATE);
  assign head_in_range = head_index_i < NEXT_W'(RING_ENTRIES);
  assign next_in_range = rd_entry_i.next < NEXT_W'(RING_ENTRIES);
  assign next_seen     = visited_q[rd_entry_i.next[IDX_W-1:0]];

  // checks on the entry just read
  assign step_fail = !rd_entry_i.len_nonzero || rd_entry_i.indirect ||
                     (rd_entry_i.has_next && (!next_in_range || next_seen));
  assign step_end  = step_fail || !rd_entry_i.has_next;

  always_comb begin
    state_d = state_q;
    case (state_q)
      WalkIdle: begin
        if (validate && head_in_range) begin
          state_d = WalkStep;
        end
      end
      WalkStep: begin
        if (step_end) begin
          state_d = WalkIdle;
        end
      end
      default: state_d = WalkIdle;
    endcase
  end

  always_comb begin
    rd_req_o  = '0;
    visited_d = visited_q;
    done_d    = 1'b0;
    ok_d      = ok_q;
    case (state_q)
      WalkIdle: begin
        if (validate) begin
          if (head_in_range) begin
            rd_req_o.en   = 1'b1;
            rd_req_o.addr = head_index_i[IDX_W-1:0];
            visited_d     = '0;
            visited_d[head_index_i[IDX_W-1:0]] = 1'b1;
          end else begin
            done_d = 1'b1;
            ok_d   = 1'b0;
          end
        end
      end
      WalkStep: begin
        if (step_end) begin
          done_d = 1'b1;
          ok_d   = !step_fail;
        end else begin
          rd_req_o.en   = 1'b1;
          rd_req_o.addr = rd_entry_i.next[IDX_W-1:0];
          visited_d[rd_entry_i.next[IDX_W-1:0]] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WalkIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    visited_q <= visited_d;
    ok_q      <= ok_d;
  end

  assign busy_o     = (state_q != WalkIdle);
  assign done_o     = done_q;
  assign chain_ok_o = ok_q;

endmodule

`default_nettype wire

@@ hdl/virtqueue_chain_checker_unit.sv @@
// split virtqueue descriptor chain checker
//
// command channel: an item is taken at a rising edge with start_i high and
// busy_o low. kind_i low writes one descriptor into slot slot_i of a
// sixteen-entry table (only length_i zero/nonzero, the next and indirect
// flags and next_index_i are kept). kind_i high walks the chain that starts
// at head_index_i and reports chain_ok_o.
// result channel: done_o is high for exactly one cycle with chain_ok_o; the
// receiver cannot stall it, so nothing is ever held back.
// flow: a write finishes at its accept edge and gives no result; busy_o
// stays low. a validate item whose head is out of range gives its result
// in the cycle after accept. otherwise the walk reads one table entry per
// cycle through the synchronous memory port and keeps busy_o high until
// the last entry of the chain is checked; a chain holds at most
// RING_ENTRIES entries. the next item may be given in the cycle that
// done_o is shown.
// a write and the read of the next validate item never meet on one entry
// in the same cycle, so no forwarding is needed.
// reset: asynchronous, active low; the table reads as all zero afterwards
// (per-entry valid bits), no clearing pass.
`default_nettype none

module virtqueue_chain_checker_unit #(
  parameter int unsigned RING_ENTRIES = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire         kind_i,
  input  wire  [3:0]  slot_i,
  input  wire  [31:0] length_i,
  input  wire  [15:0] flag_bits_i,
  input  wire  [15:0] next_index_i,
  input  wire  [15:0] head_index_i,
  output logic        done_o,
  output logic        chain_ok_o
);
  import vcc_pkg::*;

  rd_req_t rd_req;
  entry_t  rd_entry;
  entry_t  wr_entry;
  logic    wr_en;

  // write items land in the table at their accept edge
  assign wr_en = start_i && !busy_o && (kind_i == KIND_WRITE);

  // only nonzero length, two flag bits and the next index matter to the walk
  always_comb begin
    wr_entry.len_nonzero = |length_i;
    wr_entry.has_next    = flag_bits_i[FLAG_NEXT];
    wr_entry.indirect    = flag_bits_i[FLAG_INDIRECT];
    wr_entry.next        = next_index_i;
  end

  vcc_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_req_i   (rd_req),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_addr_i  (slot_i),
    .wr_entry_i (wr_entry)
  );

  // chain walk sequencer, one entry per cycle
  vcc_walker #(
    .RING_ENTRIES (RING_ENTRIES)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .kind_i       (kind_i),
    .head_index_i (head_index_i),
    .rd_entry_i   (rd_entry),
    .rd_req_o     (rd_req),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .chain_ok_o   (chain_ok_o)
  );

endmodule

`default_nettype wire

@@ hdl/vcc_checker.sv @@
`default_nettype none

module vcc_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        start_i,
  input wire        busy_o,
  input wire        kind_i,
  input wire [15:0] head_index_i,
  input wire        done_o,
  input wire        chain_ok_o
);
  import vcc_pkg::*;

  // a write never makes the block busy
  a_write_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && kind_i == KIND_WRITE) |=> !busy_o)
    else $error("busy after a write item");

  // a head beyond the table fails at once
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && kind_i == KIND_VALIDATE && head_index_i >= 16'(TABLE_DEPTH))
      |=> (done_o && !chain_ok_o && !busy_o))
    else $error("out of range head not rejected");

  // a walk starts only from a validate item
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && kind_i == KIND_VALIDATE))
    else $error("walk without a validate item");

  // every walk ends with a result
  a_walk_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("walk ended without a result");

endmodule

bind virtqueue_chain_checker_unit vcc_checker u_vcc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .kind_i       (kind_i),
  .head_index_i (head_index_i),
  .done_o       (done_o),
  .chain_ok_o   (chain_ok_o)
);

`default_nettype wire
